// ===== design/multibase_int_literal_parser_macros.svh =====
// ----------------------------------------------------------------------------
// multibase integer literal parser assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MULTIBASE_INT_LITERAL_PARSER_MACROS_SVH
`define MULTIBASE_INT_LITERAL_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MIBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MIBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MIBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MIBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/mibp_pkg.sv =====
// ----------------------------------------------------------------------------
// mibp_pkg
// types, character codes and helper functions of the integer literal parser
// ----------------------------------------------------------------------------
package mibp_pkg;

    localparam int unsigned ACCUM_WIDTH = 128;
    localparam int unsigned ACC_BITS    = 128;
    localparam int unsigned HALF_BITS   = 64;

    // bits above ACCUM_WIDTH are always zero
    localparam logic [ACC_BITS-1:0] ACCUM_MASK =
        (ACC_BITS'(1) << ACCUM_WIDTH) - ACC_BITS'(1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7a;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5a;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_S     = 8'h73;

    typedef enum logic [1:0] {
        RADIX_10 = 2'd0,
        RADIX_3  = 2'd1,
        RADIX_9  = 2'd2,
        RADIX_27 = 2'd3
    } radix_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] value_low;
        logic [63:0] value_high;
    } out_item_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } digit_t;

    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t     d;
        logic [7:0] t;
        d.ok    = 1'b0;
        d.value = '0;
        t       = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t       = c - CH_ZERO;
            d.ok    = 1'b1;
            d.value = t[5:0];
        end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
            t       = c - CH_LC_A + 8'd10;
            d.ok    = 1'b1;
            d.value = t[5:0];
        end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
            t       = c - CH_UC_A + 8'd10;
            d.ok    = 1'b1;
            d.value = t[5:0];
        end
        return d;
    endfunction

    function automatic logic [5:0] radix_value(input radix_t r);
        logic [5:0] v;
        case (r)
            RADIX_3:  v = 6'd3;
            RADIX_9:  v = 6'd9;
            RADIX_27: v = 6'd27;
            default:  v = 6'd10;
        endcase
        return v;
    endfunction

    function automatic radix_t prefix_radix(input logic [7:0] c);
        radix_t r;
        if (c == CH_T) begin
            r = RADIX_3;
        end else if (c == CH_N) begin
            r = RADIX_9;
        end else begin
            r = RADIX_27;
        end
        return r;
    endfunction

endpackage

// ===== design/mibp_mul_add.sv =====
// ----------------------------------------------------------------------------
// mibp_mul_add
// accumulator times small constant base plus digit, as shifts and adds
// ----------------------------------------------------------------------------
module mibp_mul_add (
    input  logic [mibp_pkg::ACC_BITS-1:0] acc,
    input  mibp_pkg::radix_t              radix,
    input  logic [5:0]                    digit,
    output logic [mibp_pkg::ACC_BITS-1:0] result
);
    import mibp_pkg::*;

    logic [ACC_BITS-1:0] scaled;

    always_comb
    begin
        case (radix)
            RADIX_3:  scaled = (acc << 1) + acc;
            RADIX_9:  scaled = (acc << 3) + acc;
            RADIX_27: scaled = (acc << 4) + (acc << 3) + (acc << 1) + acc;
            default:  scaled = (acc << 3) + (acc << 1);
        endcase
    end

    assign result = (scaled + ACC_BITS'(digit)) & ACCUM_MASK;

endmodule

// ===== design/multibase_int_literal_parser.sv =====
// ----------------------------------------------------------------------------
// multibase_int_literal_parser
// parses one integer literal per request sequence, base 10 or 0t/0n/0s prefix
// ----------------------------------------------------------------------------
// usage:
//   in channel: one character request per cycle (char_code, char_present,
//   is_last). the request with is_last set closes the literal.
//   out channel: one result per literal (ok, value_low, value_high), values
//   zero when ok is low.
//   result path: a last request is taken into the input register, and its
//   result into the output register once the result slot is free.
//   throughput: one request per cycle unless a last request waits; the
//   accumulator update (shift-add multiply by the base) is combinational.
//   reset: clears the literal state to base 10, value zero, no result pending.
//   stall: while a result waits on out_ready, non-last requests keep flowing;
//   a last request waits in the input register until the result slot frees,
//   and in_ready drops only then.
// ----------------------------------------------------------------------------
`include "multibase_int_literal_parser_macros.svh"

module multibase_int_literal_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mibp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mibp_pkg::out_item_t out_data
);
    import mibp_pkg::*;

    logic                in_valid_reg;
    in_item_t            in_data_reg;
    logic [1:0]          position_reg, position_next;
    logic                first_zero_reg, first_zero_next;
    radix_t              radix_reg, radix_next;
    logic [ACC_BITS-1:0] acc_reg, acc_next;
    logic                saw_digit_reg, saw_digit_next;
    logic                failed_reg, failed_next;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic [1:0]          upd_position;
    logic                upd_first_zero;
    radix_t              upd_radix;
    logic [ACC_BITS-1:0] upd_acc;
    logic                upd_saw_digit;
    logic                upd_failed;
    logic                good;
    out_item_t           result;

    logic                advance;
    logic                closing;
    logic [7:0]          c;
    digit_t              dig;
    logic                is_sep;
    logic                is_prefix;
    logic [ACC_BITS-1:0] mul_out;

    assign c       = in_data_reg.char_code;
    assign dig     = digit_of(c);
    assign is_sep  = (c == CH_UNDER) || (c == CH_APOS);
    assign is_prefix = (c == CH_T) || (c == CH_N) || (c == CH_S);

    // a last request needs the result slot
    assign advance  = in_valid_reg && (!in_data_reg.is_last || !out_valid_reg || out_ready);
    assign closing  = advance && in_data_reg.is_last;
    assign in_ready = !in_valid_reg || advance;

    mibp_mul_add u_mul_add (
        .acc    (acc_reg),
        .radix  (radix_reg),
        .digit  (dig.value),
        .result (mul_out)
    );

    always_comb
    begin
        upd_position   = position_reg;
        upd_first_zero = first_zero_reg;
        upd_radix      = radix_reg;
        upd_acc        = acc_reg;
        upd_saw_digit  = saw_digit_reg;
        upd_failed     = failed_reg;
        if (in_data_reg.char_present)
        begin
            if (position_reg != 2'd2)
            begin
                upd_position = position_reg + 2'd1;
            end
            // "0t", "0n", "0s": switch base and drop the leading zero
            if (position_reg == 2'd1 && first_zero_reg && is_prefix)
            begin
                upd_radix     = prefix_radix(c);
                upd_acc       = '0;
                upd_saw_digit = 1'b0;
            end
            else
            begin
                if (position_reg == 2'd0 && c == CH_ZERO)
                begin
                    upd_first_zero = 1'b1;
                end
                if (!is_sep && !failed_reg)
                begin
                    if (!dig.ok || dig.value >= radix_value(radix_reg))
                    begin
                        upd_failed = 1'b1;
                    end
                    else
                    begin
                        upd_acc       = mul_out;
                        upd_saw_digit = 1'b1;
                    end
                end
            end
        end

        good             = upd_saw_digit && !upd_failed;
        result.ok        = good;
        result.value_low = good ? upd_acc[HALF_BITS-1:0] : '0;
        result.value_high = good ? upd_acc[ACC_BITS-1:HALF_BITS] : '0;

        if (in_data_reg.is_last)
        begin
            position_next   = '0;
            first_zero_next = 1'b0;
            radix_next      = RADIX_10;
            acc_next        = '0;
            saw_digit_next  = 1'b0;
            failed_next     = 1'b0;
        end
        else
        begin
            position_next   = upd_position;
            first_zero_next = upd_first_zero;
            radix_next      = upd_radix;
            acc_next        = upd_acc;
            saw_digit_next  = upd_saw_digit;
            failed_next     = upd_failed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            position_reg   <= '0;
            first_zero_reg <= 1'b0;
            radix_reg      <= RADIX_10;
            acc_reg        <= '0;
            saw_digit_reg  <= 1'b0;
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                position_reg   <= position_next;
                first_zero_reg <= first_zero_next;
                radix_reg      <= radix_next;
                acc_reg        <= acc_next;
                saw_digit_reg  <= saw_digit_next;
                failed_reg     <= failed_next;
            end
            if (closing)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (closing)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MIBP_ASSERT_SAME(a_fail_zero, clk, rst_n,
        out_valid_reg && !out_data_reg.ok,
        out_data_reg.value_low == '0 && out_data_reg.value_high == '0)
    `MIBP_ASSERT_NEXT(a_close_gives_result, clk, rst_n, closing, out_valid_reg)
    `MIBP_ASSERT_NEXT(a_close_clears_state, clk, rst_n, closing,
        position_reg == 2'd0 && !saw_digit_reg && !failed_reg && acc_reg == '0)
    `MIBP_ASSERT_SAME(a_prefix_position, clk, rst_n, radix_reg != RADIX_10,
        position_reg == 2'd2 && first_zero_reg)
    `MIBP_ASSERT_SAME(a_acc_masked, clk, rst_n, 1'b1, (acc_reg & ~ACCUM_MASK) == '0)

endmodule

// ===== test/multibase_int_literal_parser_checker.sv =====
// ----------------------------------------------------------------------------
// multibase_int_literal_parser_checker
// watches both channels, predicts each literal's result from the accepted
// character requests and compares every accepted result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multibase_int_literal_parser_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  mibp_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  mibp_pkg::out_item_t out_data,
    output int                  errors,
    output int                  pending,
    output int                  requests_seen,
    output int                  results_seen,
    output int                  ok_results
);

    localparam int unsigned BASE_DEC  = 10;
    localparam int unsigned BASE_TER  = 3;
    localparam int unsigned BASE_NON  = 9;
    localparam int unsigned BASE_HEPT = 27;
    localparam int          REPORT_LIMIT = 10;

    // literal state as the parser should hold it
    logic [1:0]   seen_chars;
    logic         lead_zero;
    int unsigned  lit_base;
    logic [127:0] acc_value;
    logic         have_digit;
    logic         bad_char;

    mibp_pkg::out_item_t literal_results[$];

    function automatic int digit_weight(input logic [7:0] c);
        int w;
        w = -1;
        if (c >= mibp_pkg::CH_ZERO && c <= mibp_pkg::CH_NINE) begin
            w = int'(c - mibp_pkg::CH_ZERO);
        end else if (c >= mibp_pkg::CH_LC_A && c <= mibp_pkg::CH_LC_Z) begin
            w = int'(c - mibp_pkg::CH_LC_A) + 10;
        end else if (c >= mibp_pkg::CH_UC_A && c <= mibp_pkg::CH_UC_Z) begin
            w = int'(c - mibp_pkg::CH_UC_A) + 10;
        end
        return w;
    endfunction

    task automatic restart_literal();
        seen_chars = 2'd0;
        lead_zero  = 1'b0;
        lit_base   = BASE_DEC;
        acc_value  = '0;
        have_digit = 1'b0;
        bad_char   = 1'b0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        logic [1:0] at;
        int         w;
        at = seen_chars;
        w  = digit_weight(c);
        if (seen_chars != 2'd2) begin
            seen_chars = seen_chars + 2'd1;
        end
        if (at == 2'd1 && lead_zero &&
            (c == mibp_pkg::CH_T || c == mibp_pkg::CH_N || c == mibp_pkg::CH_S)) begin
            // radix prefix: drop the leading zero and start over
            lit_base   = (c == mibp_pkg::CH_T) ? BASE_TER :
                         (c == mibp_pkg::CH_N) ? BASE_NON : BASE_HEPT;
            acc_value  = '0;
            have_digit = 1'b0;
        end else begin
            if (at == 2'd0 && c == mibp_pkg::CH_ZERO) begin
                lead_zero = 1'b1;
            end
            if (c != mibp_pkg::CH_UNDER && c != mibp_pkg::CH_APOS && !bad_char) begin
                if (w < 0 || w >= int'(lit_base)) begin
                    bad_char = 1'b1;
                end else begin
                    acc_value  = (acc_value * 128'(lit_base) + 128'(w)) & mibp_pkg::ACCUM_MASK;
                    have_digit = 1'b1;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        mibp_pkg::out_item_t want;
        logic                good;
        if (!rst_n) begin
            restart_literal();
            literal_results.delete();
            errors        <= 0;
            pending       <= 0;
            requests_seen <= 0;
            results_seen  <= 0;
            ok_results    <= 0;
        end else begin
            if (in_valid && in_ready) begin
                requests_seen <= requests_seen + 1;
                if (in_data.char_present) begin
                    absorb_char(in_data.char_code);
                end
                if (in_data.is_last) begin
                    good            = have_digit && !bad_char;
                    want.ok         = good;
                    want.value_low  = good ? acc_value[63:0] : 64'd0;
                    want.value_high = good ? acc_value[127:64] : 64'd0;
                    literal_results.push_back(want);
                    restart_literal();
                end
            end
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (out_data.ok === 1'b1) begin
                    ok_results <= ok_results + 1;
                end
                if (literal_results.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < REPORT_LIMIT) begin
                        $display("[%0t] unexpected result ok=%b low=%h high=%h", $realtime,
                                 out_data.ok, out_data.value_low, out_data.value_high);
                    end
                end else begin
                    want = literal_results.pop_front();
                    if (out_data.ok !== want.ok || out_data.value_low !== want.value_low ||
                        out_data.value_high !== want.value_high) begin
                        errors <= errors + 1;
                        if (errors < REPORT_LIMIT) begin
                            $display("[%0t] result mismatch: expected ok=%b low=%h high=%h",
                                     $realtime, want.ok, want.value_low, want.value_high);
                            $display("[%0t]                  got      ok=%b low=%h high=%h",
                                     $realtime, out_data.ok, out_data.value_low,
                                     out_data.value_high);
                        end
                    end
                end
            end
            pending <= literal_results.size();
        end
    end

endmodule

// ===== test/multibase_int_literal_parser_test.sv =====
// ----------------------------------------------------------------------------
// multibase_int_literal_parser_test
// drives character requests into the literal parser under several idle and
// stall mixes plus one long output hold; the checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multibase_int_literal_parser_test;

    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 200;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    mibp_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    mibp_pkg::out_item_t out_data;

    int errors;
    int pending;
    int requests_seen;
    int results_seen;
    int ok_results;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    bit hold_armed    = 1'b0;
    int hold_count    = 0;

    int send_mix[4] = '{0, 68, 0, 38};
    int recv_mix[4] = '{0, 0, 68, 38};

    always #4 clk = ~clk;

    multibase_int_literal_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    multibase_int_literal_parser_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .errors        (errors),
        .pending       (pending),
        .requests_seen (requests_seen),
        .results_seen  (results_seen),
        .ok_results    (ok_results)
    );

    // result side: random stalls, plus one long hold once armed
    always @(negedge clk) begin
        if (hold_armed && hold_count < HOLD_CYCLES) begin
            out_ready  <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            out_ready <= (int'($urandom_range(99)) >= stall_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_char(input logic [7:0] code, input logic present,
                              input logic last);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{char_code: code, char_present: present, is_last: last};
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] digit_char(input int v);
        logic [7:0] c;
        if (v < 10) begin
            c = mibp_pkg::CH_ZERO + 8'(v);
        end else begin
            c = ($urandom_range(1) ? mibp_pkg::CH_LC_A : mibp_pkg::CH_UC_A) + 8'(v - 10);
        end
        return c;
    endfunction

    task automatic send_random_literal();
        int         kind;
        int         sel;
        int         radix;
        int         ndig;
        int         bad_at;
        bit         bare_close;
        logic [7:0] prefix;
        kind = int'($urandom_range(99));
        if (kind < 20) begin
            // noise: arbitrary bytes, present or not
            ndig = int'($urandom_range(6));
            for (int i = 0; i < ndig; i++) begin
                offer_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
            end
            offer_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end else begin
            sel    = int'($urandom_range(3));
            radix  = 10;
            prefix = mibp_pkg::CH_T;
            case (sel)
                1: begin radix = 3;  prefix = mibp_pkg::CH_T; end
                2: begin radix = 9;  prefix = mibp_pkg::CH_N; end
                3: begin radix = 27; prefix = mibp_pkg::CH_S; end
                default: radix = 10;
            endcase
            if (sel != 0) begin
                offer_char(mibp_pkg::CH_ZERO, 1'b1, 1'b0);
                offer_char(prefix, 1'b1, 1'b0);
            end
            // long literals can wrap the 128-bit value
            ndig       = ($urandom_range(9) == 0) ? int'($urandom_range(90, 30))
                                                  : int'($urandom_range(8, 1));
            bad_at     = (kind < 32) ? int'($urandom_range(ndig - 1)) : -1;
            bare_close = ($urandom_range(3) == 0);
            for (int i = 0; i < ndig; i++) begin
                if ($urandom_range(7) == 0) begin
                    offer_char($urandom_range(1) ? mibp_pkg::CH_UNDER : mibp_pkg::CH_APOS,
                               1'b1, 1'b0);
                end
                if ($urandom_range(15) == 0) begin
                    offer_char(8'($urandom_range(255)), 1'b0, 1'b0);
                end
                offer_char(digit_char((i == bad_at) ? int'($urandom_range(35, radix))
                                                    : int'($urandom_range(radix - 1))),
                           1'b1, (i == ndig - 1) && !bare_close);
            end
            if (bare_close) begin
                offer_char(8'($urandom_range(255)), 1'b0, 1'b1);
            end
        end
    endtask

    initial begin
        int target;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single zero, plain decimal
        offer_char(mibp_pkg::CH_ZERO, 1'b1, 1'b1);
        // ternary prefix
        offer_char(mibp_pkg::CH_ZERO, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_T, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_ZERO + 8'd1, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_ZERO + 8'd2, 1'b1, 1'b1);
        // base 27 with upper and lower case letters
        offer_char(mibp_pkg::CH_ZERO, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_S, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_UC_A + 8'd16, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_LC_Z, 1'b1, 1'b1);
        // base 9 prefix alone, closed by a bare marker: no digits
        offer_char(mibp_pkg::CH_ZERO, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_N, 1'b1, 1'b0);
        offer_char(8'hff, 1'b0, 1'b1);
        // empty literal
        offer_char(8'h00, 1'b0, 1'b1);
        // separators and a bare marker in the middle
        offer_char(mibp_pkg::CH_NINE, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_UNDER, 1'b1, 1'b0);
        offer_char(8'h00, 1'b0, 1'b0);
        offer_char(mibp_pkg::CH_APOS, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_NINE, 1'b1, 1'b1);
        // letter out of range in decimal
        offer_char(mibp_pkg::CH_ZERO, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_LC_A, 1'b1, 1'b1);
        // high byte
        offer_char(8'hff, 1'b1, 1'b1);
        // digit too large for base 3
        offer_char(mibp_pkg::CH_ZERO, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_T, 1'b1, 1'b0);
        offer_char(mibp_pkg::CH_ZERO + 8'd3, 1'b1, 1'b1);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_mix[p];
            stall_pct     = recv_mix[p];
            target        = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                send_random_literal();
            end
        end

        // long output hold with the sender pushing one-digit literals
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_armed   <= 1'b1;
        for (int i = 0; i < 50; i++) begin
            offer_char(digit_char(int'($urandom_range(9))), 1'b1, 1'b1);
        end
        in_valid <= 1'b0;

        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("covered %0d character requests and %0d literal results (%0d ok)",
                 requests_seen, results_seen, ok_results);
        $display("idle mixes: none, sender, receiver, both, then a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("multibase_int_literal_parser_test passed");
        end else begin
            $display("multibase_int_literal_parser_test failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("multibase_int_literal_parser_test failed");
        $finish;
    end

endmodule
